[rtl/rpg_pkg.sv]
// Shared constants for the radar point gate: register indexes, CORDIC
// arctangent table, gain correction and range limits.
// No dependencies.
package rpg_pkg;

    localparam int GUARD_BITS = 8;
    localparam int ANG_WIDTH  = 34;
    localparam int TABLE_LEN  = 24;
    localparam int CFG_WIDTH  = 18;
    localparam int IDX_WIDTH  = 3;

    localparam logic [15:0] INV_GAIN  = 16'd39797;
    localparam logic [17:0] RANGE_SAT = 18'h3FFFF;

    localparam logic [IDX_WIDTH-1:0] CFG_POINT_FORMAT    = 3'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_MIN_INTENSITY   = 3'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_MIN_RANGE       = 3'd2;
    localparam logic [IDX_WIDTH-1:0] CFG_MAX_RANGE       = 3'd3;
    localparam logic [IDX_WIDTH-1:0] CFG_AZIMUTH_LIMIT   = 3'd4;
    localparam logic [IDX_WIDTH-1:0] CFG_ELEVATION_LIMIT = 3'd5;

    // arctan(2^-i) in units of pi/2^31
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

[rtl/rpg_cordic_cell.sv]
// One CORDIC vectoring cell: a fixed-shift micro-rotation towards y = 0.
// Carries a sideband vector alongside. Depends on rpg_pkg.
module rpg_cordic_cell
    import rpg_pkg::*;
#(
    parameter int              W     = 28,
    parameter int              AW    = 34,
    parameter int              SW    = 8,
    parameter int              SHIFT = 0,
    parameter logic [AW-1:0]   ATAN  = '0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [AW-1:0] i_a,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [AW-1:0] o_a,
    output logic [SW-1:0]        o_side
);

    logic signed [W-1:0] w_dx;
    logic signed [W-1:0] w_dy;
    logic signed [W-1:0]  n_x;
    logic signed [W-1:0]  n_y;
    logic signed [AW-1:0] n_a;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    always_comb begin
        if (!i_y[W-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_a = i_a + $signed(ATAN);
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_a = i_a - $signed(ATAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_a    <= n_a;
            o_side <= i_side;
        end
    end

endmodule

[rtl/rpg_skid.sv]
// Input skid buffer: holds one beat while the pipeline is stalled so the
// stall returned upstream comes straight from a register. No dependencies.
module rpg_skid #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [DW-1:0] i_data,
    input  logic          i_en,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic          r_full;
    logic          n_full;
    logic [DW-1:0] r_data;

    assign o_stall = r_full;
    assign o_valid = r_full | i_valid;
    assign o_data  = r_full ? r_data : i_data;
    assign n_full  = !i_en && (r_full || i_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_full) begin
            r_data <= i_data;
        end
    end

endmodule

[rtl/radar_point_gate.sv]
// Radar point gate top level: axis mapping, two chained CORDIC vectoring
// passes, gain correction and gating. Depends on rpg_pkg, rpg_skid, rpg_cordic_cell.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall with one detection per beat.
//   Output channel: o_out_valid / i_out_stall with one target per kept beat;
//   dropped detections produce no beat.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; write while idle only.
//   Pipeline: stage A register, the first cell chain, stage C, the second
//   cell chain, stage E and the output register. Throughput, unless the output stalls:
//   one beat per cycle; every cell takes a new item each cycle.
//   Reset: synchronous, active low; empties the pipeline and loads the
//   register defaults (all gates pass but the range window 0..227023).
//   Stall: while the output beat is stalled the whole chain holds; the
//   input skid register takes one more beat, then o_in_stall rises.
module radar_point_gate
    import rpg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [IDX_WIDTH-1:0]          i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [11:0]            i_signal_level,
    input  logic signed [16:0]            i_doppler,
    input  logic                          i_invalid,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [17:0]                   o_target_range,
    output logic signed [15:0]            o_target_azimuth,
    output logic signed [15:0]            o_target_elevation,
    output logic signed [16:0]            o_out_doppler,
    output logic signed [11:0]            o_out_level
);

    localparam int CW  = COORD_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int W   = CW + GUARD_BITS + 2;
    localparam int AW  = ANG_WIDTH;
    localparam int MW  = W - 1;
    localparam int PW  = MW + 16;
    localparam int DW  = 3 * CW + 30;
    localparam int SW1 = 3 * CW + 31;
    localparam int SW2 = 3 * CW + 48;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] QUARTER = AW'(64'h40000000);
    localparam logic signed [AW-1:0] HALF_LSB = AW'(32768);

    // configuration registers
    logic               r_point_format;
    logic signed [11:0] r_min_intensity;
    logic [17:0]        r_min_range;
    logic [17:0]        r_max_range;
    logic [15:0]        r_az_limit;
    logic [14:0]        r_el_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_format  <= 1'b0;
            r_min_intensity <= 12'sh800;
            r_min_range     <= 18'd0;
            r_max_range     <= 18'd227023;
            r_az_limit      <= 16'd32768;
            r_el_limit      <= 15'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POINT_FORMAT:    r_point_format  <= i_cfg_data[0];
                CFG_MIN_INTENSITY:   r_min_intensity <= i_cfg_data[11:0];
                CFG_MIN_RANGE:       r_min_range     <= i_cfg_data[17:0];
                CFG_MAX_RANGE:       r_max_range     <= i_cfg_data[17:0];
                CFG_AZIMUTH_LIMIT:   r_az_limit      <= i_cfg_data[15:0];
                CFG_ELEVATION_LIMIT: r_el_limit      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;
    assign w_en = !r_out_valid || !i_out_stall;

    // input skid
    logic          s_valid;
    logic [DW-1:0] s_data;
    logic signed [CW-1:0] s_x, s_y, s_z;
    logic signed [11:0]   s_lvl;
    logic signed [16:0]   s_dop;
    logic                 s_inv;

    rpg_skid #(.DW(DW)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  ({i_pos_x, i_pos_y, i_pos_z, i_signal_level, i_doppler, i_invalid}),
        .i_en    (w_en),
        .o_valid (s_valid),
        .o_data  (s_data)
    );

    assign {s_x, s_y, s_z, s_lvl, s_dop, s_inv} = s_data;

    // stage A: axis mapping and early gating
    logic                 r_a_valid, r_a_keep;
    logic signed [CW-1:0] r_a_x, r_a_y, r_a_z;
    logic signed [11:0]   r_a_lvl;
    logic signed [16:0]   r_a_dop;
    logic signed [CW-1:0] n_a_x, n_a_y;

    always_comb begin
        if (r_point_format) begin
            n_a_x = s_y;
            n_a_y = (s_x == C_MIN) ? C_MAX : -s_x;
        end else begin
            n_a_x = s_x;
            n_a_y = s_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x    <= n_a_x;
            r_a_y    <= n_a_y;
            r_a_z    <= s_z;
            r_a_lvl  <= s_lvl;
            r_a_dop  <= s_dop;
            r_a_keep <= !s_inv && (s_lvl >= r_min_intensity);
        end
    end

    // pass one: quadrant pre-rotation into the first chain
    logic                 p1_v    [N+1];
    logic signed [W-1:0]  p1_x    [N+1];
    logic signed [W-1:0]  p1_y    [N+1];
    logic signed [AW-1:0] p1_a    [N+1];
    logic [SW1-1:0]       p1_side [N+1];
    logic signed [W-1:0]  w_gx, w_gy;
    logic                 w_org1;
    logic signed [W-1:0]  w_rx0, w_ry0;
    logic signed [AW-1:0] w_ra0;

    assign w_gx   = {{(W-CW-GUARD_BITS){r_a_x[CW-1]}}, r_a_x, {GUARD_BITS{1'b0}}};
    assign w_gy   = {{(W-CW-GUARD_BITS){r_a_y[CW-1]}}, r_a_y, {GUARD_BITS{1'b0}}};
    assign w_org1 = (r_a_x == '0) && (r_a_y == '0);

    always_comb begin
        w_rx0 = w_gx;
        w_ry0 = w_gy;
        w_ra0 = '0;
        if (w_gx[W-1]) begin
            if (!w_gy[W-1]) begin
                w_rx0 = w_gy;
                w_ry0 = -w_gx;
                w_ra0 = QUARTER;
            end else begin
                w_rx0 = -w_gy;
                w_ry0 = w_gx;
                w_ra0 = -QUARTER;
            end
        end
    end

    assign p1_x[0]    = w_rx0;
    assign p1_y[0]    = w_ry0;
    assign p1_a[0]    = w_ra0;
    assign p1_v[0]    = r_a_valid;
    assign p1_side[0] = {r_a_x, r_a_y, r_a_z, r_a_lvl, r_a_dop, r_a_keep, w_org1};

    for (genvar k = 0; k < N; k++) begin : g_pass1
        rpg_cordic_cell #(
            .W(W), .AW(AW), .SW(SW1), .SHIFT(k), .ATAN(AW'(ATAN_TAB[k]))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (p1_v[k]),
            .i_x     (p1_x[k]),
            .i_y     (p1_y[k]),
            .i_a     (p1_a[k]),
            .i_side  (p1_side[k]),
            .o_valid (p1_v[k+1]),
            .o_x     (p1_x[k+1]),
            .o_y     (p1_y[k+1]),
            .o_a     (p1_a[k+1]),
            .o_side  (p1_side[k+1])
        );
    end

    // stage C: gain correction product and azimuth rounding
    logic                 r_c_valid;
    logic [PW-1:0]        r_c_prod;
    logic signed [16:0]   r_c_az;
    logic [SW1-2:0]       r_c_side;
    logic signed [AW-1:0] w_ar1;
    logic signed [16:0]   n_c_az;

    assign w_ar1 = (p1_a[N] + HALF_LSB) >>> 16;

    always_comb begin
        if (p1_side[N][0]) begin
            n_c_az = '0;
        end else if (w_ar1 > AW'(32768)) begin
            n_c_az = 17'sd32768;
        end else if (w_ar1 < -AW'(32768)) begin
            n_c_az = -17'sd32768;
        end else begin
            n_c_az = w_ar1[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= p1_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_prod <= PW'(p1_x[N][MW-1:0]) * PW'(INV_GAIN);
            r_c_az   <= n_c_az;
            r_c_side <= p1_side[N][SW1-1:1];
        end
    end

    // pass two: (horizontal distance, z)
    logic                 p2_v    [N+1];
    logic signed [W-1:0]  p2_x    [N+1];
    logic signed [W-1:0]  p2_y    [N+1];
    logic signed [AW-1:0] p2_a    [N+1];
    logic [SW2-1:0]       p2_side [N+1];
    logic [PW-1:0]        w_rsum1;
    logic [MW-1:0]        w_rxy;
    logic signed [CW-1:0] c_z;

    assign c_z     = r_c_side[SW1-2-2*CW -: CW];
    assign w_rsum1 = r_c_prod + PW'(32768);
    assign w_rxy   = w_rsum1[MW+15:16];

    assign p2_v[0]    = r_c_valid;
    assign p2_x[0]    = {1'b0, w_rxy};
    assign p2_y[0]    = {{(W-CW-GUARD_BITS){c_z[CW-1]}}, c_z, {GUARD_BITS{1'b0}}};
    assign p2_a[0]    = '0;
    assign p2_side[0] = {r_c_side, r_c_az, (w_rxy == '0) && (c_z == '0)};

    for (genvar k = 0; k < N; k++) begin : g_pass2
        rpg_cordic_cell #(
            .W(W), .AW(AW), .SW(SW2), .SHIFT(k), .ATAN(AW'(ATAN_TAB[k]))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (p2_v[k]),
            .i_x     (p2_x[k]),
            .i_y     (p2_y[k]),
            .i_a     (p2_a[k]),
            .i_side  (p2_side[k]),
            .o_valid (p2_v[k+1]),
            .o_x     (p2_x[k+1]),
            .o_y     (p2_y[k+1]),
            .o_a     (p2_a[k+1]),
            .o_side  (p2_side[k+1])
        );
    end

    // stage E: range product and elevation rounding
    logic                 r_e_valid;
    logic [PW-1:0]        r_e_prod;
    logic signed [15:0]   r_e_el;
    logic [SW2-2:0]       r_e_side;
    logic signed [AW-1:0] w_ar2;
    logic signed [15:0]   n_e_el;

    assign w_ar2 = (p2_a[N] + HALF_LSB) >>> 16;

    always_comb begin
        if (p2_side[N][0]) begin
            n_e_el = '0;
        end else if (w_ar2 > AW'(16384)) begin
            n_e_el = 16'sd16384;
        end else if (w_ar2 < -AW'(16384)) begin
            n_e_el = -16'sd16384;
        end else begin
            n_e_el = w_ar2[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= p2_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_prod <= PW'(p2_x[N][MW-1:0]) * PW'(INV_GAIN);
            r_e_el   <= n_e_el;
            r_e_side <= p2_side[N][SW2-1:1];
        end
    end

    // stage F: range rounding, gating and output register
    logic signed [CW-1:0] e_x, e_y, e_z;
    logic signed [11:0]   e_lvl;
    logic signed [16:0]   e_dop;
    logic                 e_keep;
    logic signed [16:0]   e_az;
    logic [PW:0]          w_rsum2;
    logic [PW:0]          w_rq;
    logic [17:0]          w_range;
    logic [16:0]          w_az_abs;
    logic [15:0]          w_el_abs;
    logic                 w_pass;

    assign {e_x, e_y, e_z, e_lvl, e_dop, e_keep, e_az} = r_e_side;

    assign w_rsum2  = {1'b0, r_e_prod} + (PW+1)'(1 << 23);
    assign w_rq     = w_rsum2 >> 24;
    assign w_range  = (w_rq > (PW+1)'(RANGE_SAT)) ? RANGE_SAT : w_rq[17:0];
    assign w_az_abs = e_az[16] ? 17'(-e_az) : 17'(e_az);
    assign w_el_abs = r_e_el[15] ? 16'(-r_e_el) : 16'(r_e_el);
    assign w_pass   = e_keep
                   && (w_range >= r_min_range) && (w_range <= r_max_range)
                   && (w_az_abs <= {1'b0, r_az_limit})
                   && (w_el_abs <= {1'b0, r_el_limit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_e_valid && w_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_x            <= e_x;
            o_out_y            <= e_y;
            o_out_z            <= e_z;
            o_target_range     <= w_range;
            o_target_azimuth   <= e_az[15:0];
            o_target_elevation <= r_e_el;
            o_out_doppler      <= e_dop;
            o_out_level        <= e_lvl;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_range_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_target_range >= r_min_range) && (o_target_range <= r_max_range))
        else $error("range outside window on output beat");

    a_elev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_target_elevation <= 16'sd16384)
                     && (o_target_elevation >= -16'sd16384))
        else $error("elevation beyond quarter turn");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(!w_en))
        else $error("skid filled while pipeline advanced");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_e_valid) && $stable(r_e_prod))
        else $error("pipeline moved during output stall");
`endif

endmodule
